[sv/word_cache_lookup_lru_core_assert.svh]
// assertion macros for the cache rtl
`ifndef WORD_CACHE_LOOKUP_LRU_CORE_ASSERT_SVH
`define WORD_CACHE_LOOKUP_LRU_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define WCL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define WCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wcl_pkg.sv]
`default_nettype none

package wcl_pkg;

  // field widths
  localparam int ADDR_W  = 32;
  localparam int WORD_W  = 32;
  localparam int TAG_W   = 30;
  localparam int CNT_W   = 32;
  localparam int KIND_W  = 2;
  localparam int SLOG_W  = 4;
  localparam int OUTC_W  = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // default geometry
  localparam int DEF_MAX_SLOTS = 1024;
  localparam int DEF_WAYS      = 4;

  // cache organisation codes
  localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ASSOC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BYPASS = 2'd2;

  // lookup outcome codes
  localparam logic [OUTC_W-1:0] OUT_HIT    = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_COLD   = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_HOT    = 2'd2;
  localparam logic [OUTC_W-1:0] OUT_BYPASS = 2'd3;

  // register select (paddr bit 2)
  localparam logic REG_CACHE_KIND = 1'b0;
  localparam logic REG_SLOT_LOG2  = 1'b1;

  localparam logic [SLOG_W-1:0] SLOG_RESET = 4'd10;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] memory_word;
  } wcl_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [OUTC_W-1:0] outcome;
    logic [CNT_W-1:0]  reference_count;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  cold_miss_count;
    logic [CNT_W-1:0]  hot_miss_count;
  } wcl_rsp_t;

  // result of one set update
  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic              wr_en;
  } wcl_status_t;

endpackage

`default_nettype wire

[sv/wcl_set_update.sv]
`default_nettype none

module wcl_set_update #(
  parameter int WAYS   = wcl_pkg::DEF_WAYS,
  parameter int RANK_W = $clog2(wcl_pkg::DEF_WAYS)
) (
  input  wire logic [WAYS*(1+wcl_pkg::TAG_W+wcl_pkg::WORD_W+RANK_W)-1:0] row_in,
  input  wire logic [wcl_pkg::KIND_W-1:0]                                kind,
  input  wire logic [wcl_pkg::TAG_W-1:0]                                 tag,
  input  wire logic [wcl_pkg::WORD_W-1:0]                                word,
  input  wire logic [RANK_W-1:0]                                         dm_way,
  output logic      [WAYS*(1+wcl_pkg::TAG_W+wcl_pkg::WORD_W+RANK_W)-1:0] row_out,
  output logic      [wcl_pkg::WORD_W-1:0]                                read_data,
  output wcl_pkg::wcl_status_t                                           status
);
  import wcl_pkg::*;

  // entry layout, lsb first: rank, word, tag, valid
  localparam int ENT_W  = 1 + TAG_W + WORD_W + RANK_W;
  localparam int WD_LO  = RANK_W;
  localparam int TG_LO  = RANK_W + WORD_W;
  localparam int VL_POS = RANK_W + WORD_W + TAG_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);
  localparam logic [RANK_W:0]   RANK_NEW = (RANK_W+1)'(WAYS);

  logic [WAYS-1:0]   ent_valid;
  logic [TAG_W-1:0]  ent_tag  [WAYS];
  logic [WORD_W-1:0] ent_word [WAYS];
  logic [RANK_W-1:0] ent_rank [WAYS];
  logic [WAYS-1:0]   match;

  logic              any_hit;
  logic              any_free;
  logic [RANK_W-1:0] hit_way;
  logic [RANK_W-1:0] free_way;
  logic [RANK_W-1:0] victim_way;
  logic [RANK_W:0]   best_rank;
  logic [RANK_W-1:0] sel_way;
  logic [RANK_W:0]   old_rank;

  // split the row into its ways
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      ent_valid[i] = row_in[i*ENT_W + VL_POS];
      ent_tag[i]   = row_in[i*ENT_W + TG_LO +: TAG_W];
      ent_word[i]  = row_in[i*ENT_W + WD_LO +: WORD_W];
      ent_rank[i]  = row_in[i*ENT_W +: RANK_W];
      match[i]     = ent_valid[i] && (ent_tag[i] == tag);
    end
  end

  // lowest matching way, lowest empty way, oldest way
  always_comb begin
    any_hit    = 1'b0;
    any_free   = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    victim_way = '0;
    best_rank  = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_hit = 1'b1;
        hit_way = RANK_W'(i);
      end
      if (!ent_valid[i]) begin
        any_free = 1'b1;
        free_way = RANK_W'(i);
      end
    end
    // strictly greater keeps ties on the lowest way
    for (int i = 0; i < WAYS; i++) begin
      if ({1'b0, ent_rank[i]} > best_rank) begin
        best_rank  = {1'b0, ent_rank[i]};
        victim_way = RANK_W'(i);
      end
    end
  end

  // outcome, returned word and the row to write back
  always_comb begin
    row_out        = row_in;
    read_data      = word;
    status.outcome = OUT_BYPASS;
    status.wr_en   = 1'b0;
    sel_way        = '0;
    old_rank       = '0;
    case (kind)
      KIND_DIRECT: begin
        if (match[dm_way]) begin
          read_data      = ent_word[dm_way];
          status.outcome = OUT_HIT;
        end else begin
          status.outcome = ent_valid[dm_way] ? OUT_HOT : OUT_COLD;
          status.wr_en   = 1'b1;
          // fill leaves the rank field alone
          for (int i = 0; i < WAYS; i++) begin
            if (RANK_W'(i) == dm_way) begin
              row_out[i*ENT_W + VL_POS]         = 1'b1;
              row_out[i*ENT_W + TG_LO +: TAG_W]  = tag;
              row_out[i*ENT_W + WD_LO +: WORD_W] = word;
            end
          end
        end
      end
      KIND_ASSOC: begin
        status.wr_en = 1'b1;
        if (any_hit) begin
          sel_way        = hit_way;
          old_rank       = {1'b0, ent_rank[hit_way]};
          read_data      = ent_word[hit_way];
          status.outcome = OUT_HIT;
        end else if (any_free) begin
          sel_way        = free_way;
          old_rank       = RANK_NEW;
          status.outcome = OUT_COLD;
        end else begin
          sel_way        = victim_way;
          old_rank       = best_rank;
          status.outcome = OUT_HOT;
        end
        // touched way becomes youngest, younger valid ways age by one
        for (int i = 0; i < WAYS; i++) begin
          if (RANK_W'(i) == sel_way) begin
            row_out[i*ENT_W +: RANK_W] = '0;
            if (!any_hit) begin
              row_out[i*ENT_W + VL_POS]         = 1'b1;
              row_out[i*ENT_W + TG_LO +: TAG_W]  = tag;
              row_out[i*ENT_W + WD_LO +: WORD_W] = word;
            end
          end else if (ent_valid[i] && ({1'b0, ent_rank[i]} < old_rank) &&
                       (ent_rank[i] < RANK_MAX)) begin
            row_out[i*ENT_W +: RANK_W] = ent_rank[i] + RANK_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/word_cache_lookup_lru_core.sv]
`default_nettype none

// One-word-per-line read cache with counters. Each request carries a byte
// address and the word memory holds there; one response comes back per
// request with the word, the outcome and the four counters after the read.
// cache_kind selects direct mapped, WAYS-way set associative with true LRU
// (ties to the lowest way) or bypass. All ways of a set share one row of a
// single-port-per-direction synchronous memory: the row is read on the
// request transfer and the updated row is written back when the update
// completes, and the next request is taken only after the write back,
// which keeps back-to-back accesses to one set coherent. A held response
// delays the write back, and with it the next request transfer. After
// reset the memory is cleared one row per cycle, and req_stall is high
// until the clear is done; register writes are taken at any time.
module word_cache_lookup_lru_core #(
  parameter int MAX_SLOTS = wcl_pkg::DEF_MAX_SLOTS,
  parameter int WAYS      = wcl_pkg::DEF_WAYS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire wcl_pkg::wcl_req_t            req,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output wcl_pkg::wcl_rsp_t                 rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wcl_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [wcl_pkg::PDATA_W-1:0]  pwdata,
  output logic      [wcl_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);
  import wcl_pkg::*;

  `include "word_cache_lookup_lru_core_assert.svh"

  localparam int RANK_W   = $clog2(WAYS);
  localparam int ENT_W    = 1 + TAG_W + WORD_W + RANK_W;
  localparam int ROW_BITS = WAYS * ENT_W;
  localparam int ROWS     = (MAX_SLOTS + WAYS - 1) / WAYS;
  localparam int RA_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W    = $clog2(MAX_SLOTS);
  localparam int SHAMT_W  = $clog2(IDX_W + 3);
  localparam int NS       = 1 << SLOG_W;
  // reciprocal of WAYS for the direct-mapped slot split
  localparam int RSH      = IDX_W + RANK_W;
  localparam int RECIP_W  = RSH + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RSH) + WAYS - 1) / WAYS);

  // slots in use for a slot_count_log2 code
  function automatic int slot_n(input int s);
    int n;
    n = (s < 2) ? 4 : (1 << s);
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return n;
  endfunction

  function automatic int sets_for(input int s, input bit assoc);
    int n;
    n = slot_n(s);
    if (assoc) n = n / WAYS;
    if (n < 1) n = 1;
    return n;
  endfunction

  function automatic int floor_log2(input int v);
    int b;
    b = 0;
    for (int i = 1; i < 31; i++) begin
      if ((v >> i) != 0) b = i;
    end
    return b;
  endfunction

  function automatic logic [NS*IDX_W-1:0] mask_table(input bit assoc);
    logic [NS*IDX_W-1:0] t;
    t = '0;
    for (int s = 0; s < NS; s++) begin
      t[s*IDX_W +: IDX_W] = IDX_W'(sets_for(s, assoc) - 1);
    end
    return t;
  endfunction

  function automatic logic [NS*SHAMT_W-1:0] shift_table(input bit assoc);
    logic [NS*SHAMT_W-1:0] t;
    t = '0;
    for (int s = 0; s < NS; s++) begin
      t[s*SHAMT_W +: SHAMT_W] = SHAMT_W'(floor_log2(sets_for(s, assoc)) + 2);
    end
    return t;
  endfunction

  localparam logic [NS*IDX_W-1:0]   DM_MASKS  = mask_table(1'b0);
  localparam logic [NS*IDX_W-1:0]   SA_MASKS  = mask_table(1'b1);
  localparam logic [NS*SHAMT_W-1:0] DM_SHIFTS = shift_table(1'b0);
  localparam logic [NS*SHAMT_W-1:0] SA_SHIFTS = shift_table(1'b1);

  // configuration registers
  logic [KIND_W-1:0] cfg_kind;
  logic [SLOG_W-1:0] cfg_slog;
  logic              cfg_wr;

  // control
  logic            clearing;
  logic [RA_W-1:0] clr_row;
  logic            busy;
  logic            req_fire;
  logic            complete;

  // request decode
  logic                     assoc_sel;
  logic [IDX_W-1:0]         set_mask;
  logic [SHAMT_W-1:0]       tag_shift;
  logic [IDX_W-1:0]         index;
  logic [IDX_W+RECIP_W-1:0] recip_prod;
  logic [IDX_W-1:0]         dm_quot;
  logic [IDX_W-1:0]         dm_rem;
  logic [RA_W-1:0]          rd_addr;

  // captured request
  logic [KIND_W-1:0] cur_kind;
  logic [TAG_W-1:0]  cur_tag;
  logic [WORD_W-1:0] cur_word;
  logic [RANK_W-1:0] cur_way;
  logic [RA_W-1:0]   cur_row;

  // memory ports
  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rd_row;
  logic                wr_en;
  logic [RA_W-1:0]     wr_addr;
  logic [ROW_BITS-1:0] wr_data;

  // set update
  logic [ROW_BITS-1:0] upd_row;
  logic [WORD_W-1:0]   upd_data;
  wcl_status_t         upd_status;

  // counters
  logic [CNT_W-1:0] lookups_total, lookups_next;
  logic [CNT_W-1:0] hits_total, hits_next;
  logic [CNT_W-1:0] cold_misses_total, cold_misses_next;
  logic [CNT_W-1:0] hot_misses_total, hot_misses_next;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_kind <= KIND_DIRECT;
      cfg_slog <= SLOG_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CACHE_KIND: cfg_kind <= pwdata[KIND_W-1:0];
        REG_SLOT_LOG2:  cfg_slog <= pwdata[SLOG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CACHE_KIND: prdata = PDATA_W'(cfg_kind);
      REG_SLOT_LOG2:  prdata = PDATA_W'(cfg_slog);
      default:        prdata = '0;
    endcase
  end

  // handshake
  assign req_stall = busy || clearing;
  assign req_fire  = req_valid && !req_stall;
  assign complete  = busy && (!rsp_valid || !rsp_stall);

  // post-reset clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      if (clr_row == RA_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_row <= clr_row + RA_W'(1);
      end
    end
  end

  // index, tag and row of the request
  always_comb begin
    assoc_sel  = (cfg_kind == KIND_ASSOC);
    set_mask   = assoc_sel ? SA_MASKS[cfg_slog*IDX_W +: IDX_W]
                           : DM_MASKS[cfg_slog*IDX_W +: IDX_W];
    tag_shift  = assoc_sel ? SA_SHIFTS[cfg_slog*SHAMT_W +: SHAMT_W]
                           : DM_SHIFTS[cfg_slog*SHAMT_W +: SHAMT_W];
    index      = req.address[IDX_W+1:2] & set_mask;
    recip_prod = (IDX_W+RECIP_W)'(index) * (IDX_W+RECIP_W)'(RECIP);
    dm_quot    = IDX_W'(recip_prod >> RSH);
    dm_rem     = index - IDX_W'(dm_quot * WAYS);
    rd_addr    = assoc_sel ? RA_W'(index) : RA_W'(dm_quot);
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur_kind <= (cfg_kind == KIND_DIRECT || cfg_kind == KIND_ASSOC) ? cfg_kind
                                                                      : KIND_BYPASS;
      cur_tag  <= TAG_W'(req.address >> tag_shift);
      cur_word <= req.memory_word;
      cur_way  <= RANK_W'(dm_rem);
      cur_row  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req_fire) begin
      busy <= 1'b1;
    end else if (complete) begin
      busy <= 1'b0;
    end
  end

  // set memory: row read on transfer, write back on completion
  assign wr_en   = clearing || (complete && upd_status.wr_en);
  assign wr_addr = clearing ? clr_row : cur_row;
  assign wr_data = clearing ? '0 : upd_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req_fire) begin
      rd_row <= mem[rd_addr];
    end
  end

  wcl_set_update #(
    .WAYS   (WAYS),
    .RANK_W (RANK_W)
  ) u_upd (
    .row_in    (rd_row),
    .kind      (cur_kind),
    .tag       (cur_tag),
    .word      (cur_word),
    .dm_way    (cur_way),
    .row_out   (upd_row),
    .read_data (upd_data),
    .status    (upd_status)
  );

  // counter next values
  always_comb begin
    lookups_next     = lookups_total;
    hits_next        = hits_total;
    cold_misses_next = cold_misses_total;
    hot_misses_next  = hot_misses_total;
    case (upd_status.outcome)
      OUT_HIT: begin
        lookups_next = lookups_total + CNT_W'(1);
        hits_next    = hits_total + CNT_W'(1);
      end
      OUT_COLD: begin
        lookups_next     = lookups_total + CNT_W'(1);
        cold_misses_next = cold_misses_total + CNT_W'(1);
      end
      OUT_HOT: begin
        lookups_next    = lookups_total + CNT_W'(1);
        hot_misses_next = hot_misses_total + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lookups_total     <= '0;
      hits_total        <= '0;
      cold_misses_total <= '0;
      hot_misses_total  <= '0;
    end else if (complete) begin
      lookups_total     <= lookups_next;
      hits_total        <= hits_next;
      cold_misses_total <= cold_misses_next;
      hot_misses_total  <= hot_misses_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (complete) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      rsp.read_data       <= upd_data;
      rsp.outcome         <= upd_status.outcome;
      rsp.reference_count <= lookups_next;
      rsp.hit_count       <= hits_next;
      rsp.cold_miss_count <= cold_misses_next;
      rsp.hot_miss_count  <= hot_misses_next;
    end
  end

  // checks
  `WCL_ASSERT_NOW(a_tally, 1'b1, (hits_total + cold_misses_total + hot_misses_total == lookups_total), "hit and miss counters disagree with lookup counter")
  `WCL_ASSERT_NEXT(a_lookup_step, (complete && upd_status.outcome != OUT_BYPASS), (lookups_total == $past(lookups_total) + CNT_W'(1)), "lookup counter missed a cached read")
  `WCL_ASSERT_NOW(a_bypass_quiet, (complete && upd_status.outcome == OUT_BYPASS), !wr_en, "bypass read wrote the set memory")
  `WCL_ASSERT_NEXT(a_fire_busy, req_fire, (busy && !clearing), "request transfer did not start an update")
  `WCL_ASSERT_NEXT(a_clear_once, !clearing, !clearing, "clearing sweep restarted outside reset")

endmodule

`default_nettype wire

[tb/word_cache_lookup_lru_core_check.sv]
module word_cache_lookup_lru_core_check #(
  parameter int MAX_SLOTS = wcl_pkg::DEF_MAX_SLOTS,
  parameter int WAYS      = wcl_pkg::DEF_WAYS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  input  wire logic                         req_stall,
  input  wire wcl_pkg::wcl_req_t            req,
  input  wire logic                         rsp_valid,
  input  wire logic                         rsp_stall,
  input  wire wcl_pkg::wcl_rsp_t            rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wcl_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [wcl_pkg::PDATA_W-1:0]  pwdata,
  input  wire logic [wcl_pkg::PDATA_W-1:0]  prdata,
  input  wire logic                         pready,
  output int                                mismatches,
  output int                                reads_in_flight
);
  import wcl_pkg::*;

  // shadow copy of the cache lines
  logic              line_valid [MAX_SLOTS];
  logic [TAG_W-1:0]  line_tag   [MAX_SLOTS];
  logic [WORD_W-1:0] line_word  [MAX_SLOTS];
  int                line_rank  [MAX_SLOTS];

  // shadow counters and registers
  logic [CNT_W-1:0]  lookups;
  logic [CNT_W-1:0]  hits;
  logic [CNT_W-1:0]  cold_misses;
  logic [CNT_W-1:0]  hot_misses;
  logic [KIND_W-1:0] kind_cfg;
  logic [SLOG_W-1:0] slot_log2_cfg;

  // responses still owed by the block, oldest first
  wcl_rsp_t owed_rsp_q[$];

  // move way to most recently used, ageing the younger valid ways of its set
  function automatic void age_ways(int base, int way, int old_rank);
    for (int i = 0; i < WAYS; i++) begin
      if (i != way && line_valid[base+i] && line_rank[base+i] < old_rank &&
          line_rank[base+i] < WAYS - 1) begin
        line_rank[base+i]++;
      end
    end
    line_rank[base+way] = 0;
  endfunction

  // one word read against the shadow cache
  function automatic wcl_rsp_t lookup_read(wcl_req_t r);
    wcl_rsp_t         res;
    int               slot_log2;
    int               slots;
    int               sets;
    int               set_bits;
    int               index;
    int               base;
    int               way;
    int               best;
    logic [TAG_W-1:0] tag;
    bit               found;
    res           = '0;
    res.read_data = r.memory_word;
    res.outcome   = OUT_BYPASS;
    if (kind_cfg == KIND_DIRECT || kind_cfg == KIND_ASSOC) begin
      // geometry from the current settings, clamped
      slot_log2 = int'(slot_log2_cfg);
      if (slot_log2 < 2) slot_log2 = 2;
      slots = 1 << slot_log2;
      if (slots > MAX_SLOTS) slots = MAX_SLOTS;
      sets = (kind_cfg == KIND_DIRECT) ? slots : slots / WAYS;
      if (sets == 0) sets = 1;
      set_bits = 0;
      while ((sets >> (set_bits + 1)) != 0) set_bits++;
      index = (r.address >> 2) & (sets - 1);
      tag   = TAG_W'(r.address >> (set_bits + 2));
      lookups++;
      found = 1'b0;
      if (kind_cfg == KIND_DIRECT) begin
        if (line_valid[index] && line_tag[index] == tag) begin
          hits++;
          res.read_data = line_word[index];
          res.outcome   = OUT_HIT;
        end else begin
          if (line_valid[index]) begin
            hot_misses++;
            res.outcome = OUT_HOT;
          end else begin
            cold_misses++;
            res.outcome = OUT_COLD;
          end
          line_valid[index] = 1'b1;
          line_tag[index]   = tag;
          line_word[index]  = r.memory_word;
        end
      end else begin
        base = index * WAYS;
        for (int i = 0; i < WAYS; i++) begin
          if (!found && line_valid[base+i] && line_tag[base+i] == tag) begin
            hits++;
            res.read_data = line_word[base+i];
            res.outcome   = OUT_HIT;
            age_ways(base, i, line_rank[base+i]);
            found = 1'b1;
          end
        end
        if (!found) begin
          // lowest empty way first, else the oldest, lowest way on a tie
          way = WAYS;
          for (int i = 0; i < WAYS; i++) begin
            if (way == WAYS && !line_valid[base+i]) way = i;
          end
          if (way != WAYS) begin
            cold_misses++;
            res.outcome = OUT_COLD;
            age_ways(base, way, WAYS);
          end else begin
            best = 0;
            way  = 0;
            for (int i = 0; i < WAYS; i++) begin
              if (line_rank[base+i] > best) begin
                best = line_rank[base+i];
                way  = i;
              end
            end
            hot_misses++;
            res.outcome = OUT_HOT;
            age_ways(base, way, best);
          end
          line_valid[base+way] = 1'b1;
          line_tag[base+way]   = tag;
          line_word[base+way]  = r.memory_word;
        end
      end
    end
    res.reference_count = lookups;
    res.hit_count       = hits;
    res.cold_miss_count = cold_misses;
    res.hot_miss_count  = hot_misses;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // watch both transfer channels and the register port
  always @(posedge clk) begin
    wcl_rsp_t           owed;
    logic [PDATA_W-1:0] reg_value;
    if (rst) begin
      for (int k = 0; k < MAX_SLOTS; k++) begin
        line_valid[k] = 1'b0;
        line_tag[k]   = '0;
        line_word[k]  = '0;
        line_rank[k]  = 0;
      end
      lookups       = '0;
      hits          = '0;
      cold_misses   = '0;
      hot_misses    = '0;
      kind_cfg      = KIND_DIRECT;
      slot_log2_cfg = SLOG_RESET;
      owed_rsp_q.delete();
    end else begin
      // response transfer against the oldest prediction
      if (rsp_valid && !rsp_stall) begin
        if (owed_rsp_q.size() == 0) begin
          $display("%0t: response with none expected, got %h", $time, rsp);
          mismatches++;
        end else begin
          owed = owed_rsp_q.pop_front();
          check_field("read_data", owed.read_data, rsp.read_data);
          check_field("outcome", 32'(owed.outcome), 32'(rsp.outcome));
          check_field("reference_count", owed.reference_count, rsp.reference_count);
          check_field("hit_count", owed.hit_count, rsp.hit_count);
          check_field("cold_miss_count", owed.cold_miss_count, rsp.cold_miss_count);
          check_field("hot_miss_count", owed.hot_miss_count, rsp.hot_miss_count);
        end
      end
      // request transfer
      if (req_valid && !req_stall) begin
        owed_rsp_q.push_back(lookup_read(req));
      end
      // register access phase
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_CACHE_KIND) begin
            kind_cfg = pwdata[KIND_W-1:0];
          end else begin
            slot_log2_cfg = pwdata[SLOG_W-1:0];
          end
        end else begin
          reg_value = (paddr[2] == REG_CACHE_KIND) ? PDATA_W'(kind_cfg) :
                                                     PDATA_W'(slot_log2_cfg);
          check_field("prdata", reg_value, prdata);
        end
      end
    end
    reads_in_flight = owed_rsp_q.size();
  end

endmodule

[tb/word_cache_lookup_lru_core_test.sv]
module word_cache_lookup_lru_core_test;
  import wcl_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 12;
  localparam int PHASE_READS  = 85;
  localparam int HOLD_CYCLES  = 100;
  localparam int POOL_MAX     = 16;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  wcl_req_t           req       = '0;
  logic               rsp_stall = 1'b0;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic               req_stall;
  logic               rsp_valid;
  wcl_rsp_t           rsp;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 mismatches;
  int                 reads_in_flight;

  // settings visited by the random part, extremes included
  logic [KIND_W-1:0] phase_kind [PHASES] = '{KIND_DIRECT, KIND_ASSOC, KIND_ASSOC, KIND_DIRECT,
                                             KIND_ASSOC, KIND_BYPASS, KIND_ASSOC, KIND_DIRECT,
                                             KIND_UNUSED, KIND_ASSOC, KIND_DIRECT, KIND_ASSOC};
  logic [SLOG_W-1:0] phase_slog [PHASES] = '{4'd10, 4'd10, 4'd2, 4'd3, 4'd4, 4'd6,
                                             4'd1, 4'd15, 4'd0, 4'd12, 4'd2, 4'd7};

  logic [31:0] addr_pool [POOL_MAX];
  int          pool_size;
  int          burst_left = 0;
  int          cycle_count = 0;
  int          rx_cycle = 0;
  int          stall_mode = 0;
  int          hold_left = 0;

  word_cache_lookup_lru_core i_dut (.*);

  word_cache_lookup_lru_core_check i_check (.*);

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // response side stall pattern, with a long hold-off now and then
  always @(negedge clk) begin
    logic stall_next;
    rx_cycle++;
    if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (rx_cycle % 1500 == 700) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      stall_next = 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 3) == 0);
        2: stall_next = ($urandom_range(0, 3) != 0);
        default: stall_next = ((rx_cycle % 8) < 3);
      endcase
    end
    rsp_stall <= stall_next;
  end

  // one word read transfer, then burst pacing; entered and left at a falling edge
  task automatic send_read(input logic [31:0] address, input logic [31:0] word);
    int gap;
    req_valid <= 1'b1;
    req       <= '{address: address, memory_word: word};
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // wait until every read has been answered and the block is quiet
  task automatic settle();
    req_valid <= 1'b0;
    while (reads_in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // setup and access phase on the register port
  task automatic reg_access(input logic write, input logic sel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // write both registers with junk in the unused bits, then read them back
  task automatic configure(input logic [KIND_W-1:0] kind, input logic [SLOG_W-1:0] slog);
    settle();
    reg_access(1'b1, REG_CACHE_KIND, ($urandom() & ~32'h3) | 32'(kind));
    reg_access(1'b0, REG_CACHE_KIND, '0);
    reg_access(1'b1, REG_SLOT_LOG2, ($urandom() & ~32'hF) | 32'(slog));
    reg_access(1'b0, REG_SLOT_LOG2, '0);
  endtask

  initial begin
    logic [31:0] address;
    logic [31:0] idx_base;
    int          pick;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // direct mapped at reset geometry: cold, hit across byte offsets, top index, eviction
    send_read(32'h0000_0000, 32'h0000_0000);
    send_read(32'h0000_0003, 32'hFFFF_FFFF);
    send_read(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_read(32'h0000_1000, 32'hA5A5_A5A5);
    send_read(32'hFFFF_FFFC, 32'h1234_5678);

    // single set of four ways over lines left by direct mapping: fills, lru eviction, ties
    configure(KIND_ASSOC, 4'd2);
    send_read(32'h0000_0010, 32'h1111_1111);
    send_read(32'h0000_0020, 32'h2222_2222);
    send_read(32'h0000_0030, 32'h3333_3333);
    send_read(32'h0000_0040, 32'h4444_4444);
    send_read(32'h0000_0013, 32'h5555_5555);
    send_read(32'h0000_0050, 32'h6666_6666);
    send_read(32'h0000_0004, 32'h7777_7777);

    // bypass, including the unused code
    configure(KIND_BYPASS, 4'd10);
    send_read(32'hFFFF_FFFF, 32'h0000_0000);
    send_read(32'h0000_0000, 32'hFFFF_FFFF);
    configure(KIND_UNUSED, 4'd10);
    send_read(32'h0000_0010, 32'hDEAD_BEEF);

    // slot count below the floor and above the ceiling
    configure(KIND_DIRECT, 4'd0);
    send_read(32'h0000_0000, 32'hCAFE_0001);
    send_read(32'h0000_0010, 32'hCAFE_0002);
    configure(KIND_DIRECT, 4'd15);
    send_read(32'h8000_0FFC, 32'hCAFE_0003);

    // random phases over a small working set clustered on a few sets
    for (int p = 0; p < PHASES; p++) begin
      configure(phase_kind[p], phase_slog[p]);
      pool_size = $urandom_range(2, POOL_MAX);
      idx_base  = $urandom_range(0, 1023);
      for (int i = 0; i < pool_size; i++) begin
        addr_pool[i] = ($urandom() & ~32'h0000_0FFC) |
                       (((idx_base + $urandom_range(0, 2)) & 32'h3FF) << 2);
      end
      for (int n = 0; n < PHASE_READS; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
          address = addr_pool[$urandom_range(0, pool_size - 1)];
          address[1:0] = 2'($urandom_range(0, 3));
          send_read(address, $urandom());
        end else if (pick < 19) begin
          send_read($urandom(), $urandom());
        end else begin
          send_read($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0,
                    $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
        end
      end
    end

    // drain and verdict
    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[word_cache_lookup_lru_core.f]
+incdir+sv
sv/wcl_pkg.sv
sv/wcl_set_update.sv
sv/word_cache_lookup_lru_core.sv
tb/word_cache_lookup_lru_core_check.sv
tb/word_cache_lookup_lru_core_test.sv
